// ----- rtl/sas_pkg.sv -----
// shared types and constants of the sprite animation sequencer
// no dependencies
package sas_pkg;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_STEER = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  localparam logic [2:0] REG_TILE_W    = 3'd0;
  localparam logic [2:0] REG_TILE_H    = 3'd1;
  localparam logic [2:0] REG_IDLE_TH   = 3'd2;
  localparam logic [2:0] REG_ALPHA     = 3'd3;
  localparam logic [2:0] REG_DEAD_ZONE = 3'd4;
  localparam logic [2:0] REG_AXIS_BIAS = 3'd5;
  localparam logic [2:0] REG_AUTO      = 3'd6;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;

  // one classified item as it travels from front to back
  typedef struct packed {
    logic [1:0]         opcode;
    logic [15:0]        time_step;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic               entry_state;
    logic [1:0]         entry_dir;
    logic [7:0]         entry_row;
    logic [7:0]         entry_start;
    logic [7:0]         entry_count;
    logic [15:0]        entry_period;
    logic               is_zero_vec;
    logic               steer_horiz;
    logic               speed_over;
  } sas_item_t;

  typedef struct packed {
    logic [16:0] rect_x;
    logic [15:0] rect_y;
    logic        motion_state;
    logic [1:0]  facing;
    logic [7:0]  frame_index;
    logic        entry_found;
  } sas_result_t;

  typedef struct packed {
    logic [8:0]  tile_width;
    logic [8:0]  tile_height;
    logic [14:0] idle_threshold;
    logic [8:0]  filter_alpha;
    logic [14:0] dead_zone;
    logic [7:0]  axis_bias;
    logic        auto_by_velocity;
  } sas_cfg_t;

  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    logic signed [16:0] e;
    e = 17'(v);
    return e[16] ? 16'(-e) : 16'(e);
  endfunction

endpackage

// ----- rtl/sprite_animation_sequencer.sv -----
// order: items pass the front part, then the queue, then the back part; a tick that
//   filters, changes state and divides takes the longest path through the back part
// flow: back part holds one item, pops the next only when idle; restoring divider (one
//   bit a cycle) sets tick time; input stalls while queue is full and front stage 1 is held
// reset: synchronous active-high rst clears table valid bits, state and queue
// depends on sas_pkg, sas_front, sas_queue, sas_back
module sprite_animation_sequencer #(
  parameter int unsigned ACCUM_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [14:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [15:0] time_step,
  input  logic signed [15:0] vel_x,
  input  logic signed [15:0] vel_y,
  input  logic        entry_state,
  input  logic [1:0]  entry_dir,
  input  logic [7:0]  entry_row,
  input  logic [7:0]  entry_start,
  input  logic [7:0]  entry_count,
  input  logic [15:0] entry_period,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] rect_x,
  output logic [15:0] rect_y,
  output logic        motion_state,
  output logic [1:0]  facing,
  output logic [7:0]  frame_index,
  output logic        entry_found
);
  import sas_pkg::*;

  sas_cfg_t    cfg;
  sas_item_t   in_item, f_item, q_head;
  sas_result_t res;
  logic        f_valid, q_full, q_ne, q_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tile_width <= 9'd32;
      cfg.tile_height <= 9'd32;
      cfg.idle_threshold <= 15'd256;
      cfg.filter_alpha <= 9'd64;
      cfg.dead_zone <= 15'd64;
      cfg.axis_bias <= 8'd16;
      cfg.auto_by_velocity <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TILE_W:    cfg.tile_width <= cfg_data[8:0];
        REG_TILE_H:    cfg.tile_height <= cfg_data[8:0];
        REG_IDLE_TH:   cfg.idle_threshold <= cfg_data;
        REG_ALPHA:     cfg.filter_alpha <= cfg_data[8:0];
        REG_DEAD_ZONE: cfg.dead_zone <= cfg_data;
        REG_AXIS_BIAS: cfg.axis_bias <= cfg_data[7:0];
        REG_AUTO:      cfg.auto_by_velocity <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_item = '0;
    in_item.opcode = opcode;
    in_item.time_step = time_step;
    in_item.vel_x = vel_x;
    in_item.vel_y = vel_y;
    in_item.entry_state = entry_state;
    in_item.entry_dir = entry_dir;
    in_item.entry_row = entry_row;
    in_item.entry_start = entry_start;
    in_item.entry_count = entry_count;
    in_item.entry_period = entry_period;
  end

  sas_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_item,
    .idle_threshold(cfg.idle_threshold),
    .q_valid(f_valid), .q_full, .q_item(f_item)
  );

  sas_queue u_queue (
    .clk, .rst, .push(f_valid), .push_item(f_item), .full(q_full),
    .pop(q_pop), .not_empty(q_ne), .head(q_head)
  );

  sas_back #(.ACCUM_BITS(ACCUM_BITS)) u_back (
    .clk, .rst, .cfg, .q_not_empty(q_ne), .q_head, .q_pop,
    .out_valid, .out_stall, .out_res(res)
  );

  assign rect_x = res.rect_x;
  assign rect_y = res.rect_y;
  assign motion_state = res.motion_state;
  assign facing = res.facing;
  assign frame_index = res.frame_index;
  assign entry_found = res.entry_found;

endmodule

// ----- rtl/sas_front.sv -----
// front part: accepts items and classifies them (zero vector, steer axis, speed test)
// depends on sas_pkg
module sas_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sas_pkg::sas_item_t   in_item,
  input  logic [14:0]          idle_threshold,
  output logic                 q_valid,
  input  logic                 q_full,
  output sas_pkg::sas_item_t   q_item
);
  import sas_pkg::*;

  // stage 0 registers the steer-classified item, stage 1 has squares, then push
  logic        s0_valid, s1_valid;
  sas_item_t   s0_item, s1_item, c_item;
  logic [31:0] sq_x, sq_y, sq_t;
  logic        adv;

  assign adv      = !(s1_valid && q_full);
  assign in_stall = !adv;
  assign q_valid  = s1_valid;

  // steer classification on the incoming item
  always_comb begin
    c_item = in_item;
    c_item.is_zero_vec = (in_item.vel_x == '0) && (in_item.vel_y == '0);
    c_item.steer_horiz = abs16(in_item.vel_x) >= abs16(in_item.vel_y);
  end

  always_comb begin
    q_item = s1_item;
    q_item.speed_over = ({1'b0, sq_x} + {1'b0, sq_y}) > {1'b0, sq_t};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s0_valid;
      s0_valid <= in_valid;
    end
    if (adv) begin
      s0_item <= c_item;
      s1_item <= s0_item;
      sq_x <= 32'(s0_item.vel_x) * 32'(s0_item.vel_x);
      sq_y <= 32'(s0_item.vel_y) * 32'(s0_item.vel_y);
      sq_t <= 32'(idle_threshold) * 32'(idle_threshold);
    end
  end

endmodule

// ----- rtl/sas_queue.sv -----
// short fifo between front and back parts
// depends on sas_pkg
module sas_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  sas_pkg::sas_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output sas_pkg::sas_item_t head
);
  import sas_pkg::*;

  sas_item_t   mem [4];
  logic [1:0]  wr_ptr, rd_ptr;
  logic [2:0]  level;

  assign full      = level == 3'd4;
  assign not_empty = level != 3'd0;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 2'd1;
      if (pop && not_empty) rd_ptr <= rd_ptr + 2'd1;
      level <= level + 3'(push && !full) - 3'(pop && not_empty);
    end
    if (push && !full) mem[wr_ptr] <= push_item;
  end

endmodule

// ----- rtl/sas_back.sv -----
// back part: table, filter, accumulator, serial divider and result register
// depends on sas_pkg
module sas_back #(
  parameter int unsigned ACCUM_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sas_pkg::sas_cfg_t    cfg,
  input  logic                 q_not_empty,
  input  sas_pkg::sas_item_t   q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sas_pkg::sas_result_t out_res
);
  import sas_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_FILT_MUL, S_FILT_ADD, S_DIR_MUL, S_DIR_DEC, S_ACC,
    S_DIV, S_WRAP, S_RECT_MUL, S_RECT, S_OUT
  } state_t;

  localparam int unsigned CNT_W = $clog2(ACCUM_BITS + 1);
  localparam logic [ACCUM_BITS-1:0] ACC_MAX = '1;

  state_t state;
  sas_item_t it;

  logic        tv   [8];
  logic [7:0]  trow [8];
  logic [7:0]  tst  [8];
  logic [7:0]  tcnt [8];
  logic [15:0] tper [8];

  logic       cur_motion;
  logic [1:0] cur_facing, prev_facing;
  logic [7:0] frame_cnt;
  logic [ACCUM_BITS-1:0] accum;
  logic signed [15:0] svx, svy;
  logic [16:0] shown_x;
  logic [15:0] shown_y;

  logic signed [26:0] px, py;
  logic [23:0] bx, by;
  logic [ACCUM_BITS-1:0] quo, rem_r, dvd;
  logic [CNT_W-1:0] bitn;
  logic [8:0] mx;
  logic [16:0] cx;
  logic [15:0] ry;
  logic       after_play;

  // running remainders of quotient and frame by the frame count
  logic [7:0] modr, fmod;
  logic [ACCUM_BITS-1:0] fsh;

  logic [2:0]  idx;
  logic [8:0]  alpha_s, tw_s, th_s;
  logic [ACCUM_BITS:0] acc_sum;
  logic [ACCUM_BITS:0] rem_sh;
  logic [7:0]  cnt1;
  logic        qbit;
  logic [8:0]  m2, f2, fs;

  assign idx     = {cur_motion, cur_facing};
  assign alpha_s = cfg.filter_alpha > 9'd256 ? 9'd256 : cfg.filter_alpha;
  assign tw_s    = cfg.tile_width > 9'd256 ? 9'd256 : cfg.tile_width;
  assign th_s    = cfg.tile_height > 9'd256 ? 9'd256 : cfg.tile_height;
  assign acc_sum = {1'b0, accum} + (ACCUM_BITS+1)'(it.time_step);
  assign rem_sh  = {rem_r, dvd[ACCUM_BITS-1]};
  assign cnt1    = tcnt[idx] == 8'd0 ? 8'd1 : tcnt[idx];
  assign q_pop   = state == S_IDLE && q_not_empty;
  assign qbit    = rem_sh >= (ACCUM_BITS+1)'(tper[idx]);
  assign m2      = {modr, qbit};
  assign f2      = {fmod, fsh[ACCUM_BITS-1]};
  assign fs      = {1'b0, modr} + {1'b0, fmod};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < 8; i++) tv[i] <= 1'b0;
      cur_motion <= 1'b0;
      cur_facing <= '0;
      prev_facing <= '0;
      frame_cnt <= '0;
      accum <= '0;
      svx <= '0;
      svy <= '0;
      shown_x <= '0;
      shown_y <= '0;
      after_play <= 1'b0;
    end else begin
      if (state == S_OUT && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_not_empty) begin
            it <= q_head;
            unique case (q_head.opcode)
              OP_WRITE: begin
                tv[{q_head.entry_state, q_head.entry_dir}] <= 1'b1;
                trow[{q_head.entry_state, q_head.entry_dir}] <= q_head.entry_row;
                tst[{q_head.entry_state, q_head.entry_dir}] <= q_head.entry_start;
                tcnt[{q_head.entry_state, q_head.entry_dir}] <= q_head.entry_count;
                tper[{q_head.entry_state, q_head.entry_dir}] <= q_head.entry_period;
                state <= S_OUT;
              end
              OP_STEER: begin
                if (q_head.is_zero_vec) begin
                  if (cur_motion) begin
                    cur_motion <= 1'b0; frame_cnt <= '0; accum <= '0;
                    after_play <= 1'b0;
                    state <= S_RECT_MUL;
                  end else state <= S_OUT;
                end else begin
                  if (q_head.steer_horiz) begin
                    cur_facing <= q_head.vel_x[15] ? 2'd2 : 2'd3;
                    prev_facing <= q_head.vel_x[15] ? 2'd2 : 2'd3;
                  end else begin
                    cur_facing <= q_head.vel_y[15] ? 2'd0 : 2'd1;
                    prev_facing <= q_head.vel_y[15] ? 2'd0 : 2'd1;
                  end
                  if (!cur_motion) begin
                    cur_motion <= 1'b1; frame_cnt <= '0; accum <= '0;
                    after_play <= 1'b0;
                    state <= S_RECT_MUL;
                  end else state <= S_OUT;
                end
              end
              OP_TICK: begin
                if (cfg.auto_by_velocity && q_head.speed_over) state <= S_FILT_MUL;
                else if (cfg.auto_by_velocity && cur_motion) begin
                  cur_motion <= 1'b0; frame_cnt <= '0; accum <= '0;
                  after_play <= 1'b1;
                  state <= S_RECT_MUL;
                end else state <= S_ACC;
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_FILT_MUL: begin
          px <= (27'(it.vel_x) - 27'(svx)) * 27'(alpha_s);
          py <= (27'(it.vel_y) - 27'(svy)) * 27'(alpha_s);
          state <= S_FILT_ADD;
        end
        S_FILT_ADD: begin
          svx <= 16'(svx + 16'(px >>> 8));
          svy <= 16'(svy + 16'(py >>> 8));
          state <= S_DIR_MUL;
        end
        S_DIR_MUL: begin
          bx <= 24'(abs16(svx)) * 24'(cfg.axis_bias);
          by <= 24'(abs16(svy)) << 4;
          state <= S_DIR_DEC;
        end
        S_DIR_DEC: begin
          if (!(abs16(svx) < 16'(cfg.dead_zone) && abs16(svy) < 16'(cfg.dead_zone))) begin
            if (bx > by) begin
              cur_facing <= svx[15] ? 2'd2 : 2'd3;
              prev_facing <= svx[15] ? 2'd2 : 2'd3;
            end else begin
              cur_facing <= svy[15] ? 2'd0 : 2'd1;
              prev_facing <= svy[15] ? 2'd0 : 2'd1;
            end
          end else cur_facing <= prev_facing;
          if (!cur_motion) begin
            cur_motion <= 1'b1; frame_cnt <= '0; accum <= '0;
            after_play <= 1'b1;
            state <= S_RECT_MUL;
          end else state <= S_ACC;
        end
        S_ACC: begin
          if (!tv[idx]) state <= S_OUT;
          else begin
            dvd <= acc_sum[ACCUM_BITS] ? ACC_MAX : acc_sum[ACCUM_BITS-1:0];
            accum <= acc_sum[ACCUM_BITS] ? ACC_MAX : acc_sum[ACCUM_BITS-1:0];
            rem_r <= '0;
            quo <= '0;
            modr <= '0;
            fmod <= '0;
            fsh <= ACCUM_BITS'(frame_cnt);
            bitn <= CNT_W'(ACCUM_BITS);
            state <= tper[idx] == 16'd0 ? S_OUT : S_DIV;
          end
        end
        S_DIV: begin
          // restoring divide, one quotient bit a cycle
          if (qbit) begin
            rem_r <= ACCUM_BITS'(rem_sh - (ACCUM_BITS+1)'(tper[idx]));
            quo <= {quo[ACCUM_BITS-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh[ACCUM_BITS-1:0];
            quo <= {quo[ACCUM_BITS-2:0], 1'b0};
          end
          // quotient and old frame reduced by the count alongside
          modr <= m2 >= {1'b0, cnt1} ? 8'(m2 - {1'b0, cnt1}) : m2[7:0];
          fmod <= f2 >= {1'b0, cnt1} ? 8'(f2 - {1'b0, cnt1}) : f2[7:0];
          fsh <= fsh << 1;
          dvd <= dvd << 1;
          bitn <= bitn - CNT_W'(1);
          if (bitn == CNT_W'(1)) state <= S_WRAP;
        end
        S_WRAP: begin
          accum <= rem_r;
          if (quo != '0) begin
            frame_cnt <= fs >= {1'b0, cnt1} ? 8'(fs - {1'b0, cnt1}) : fs[7:0];
            state <= S_RECT_MUL;
          end else state <= S_OUT;
        end
        S_RECT_MUL: begin
          cx <= 17'({1'b0, tst[idx]} + {1'b0, frame_cnt});
          mx <= tw_s;
          ry <= 16'(trow[idx]) * 16'(th_s);
          state <= S_RECT;
        end
        S_RECT: begin
          if (tv[idx]) begin
            shown_x <= 17'(cx * 17'(mx));
            shown_y <= ry;
          end
          // a state change on a tick still runs the accumulator
          after_play <= 1'b0;
          state <= after_play ? S_ACC : S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_res.rect_x <= shown_x;
            out_res.rect_y <= shown_y;
            out_res.motion_state <= cur_motion;
            out_res.facing <= cur_facing;
            out_res.frame_index <= frame_cnt;
            out_res.entry_found <= tv[idx];
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/sas_checker.sv -----
// port-level checker for the sprite animation sequencer, bound to the top level
// depends on sprite_animation_sequencer ports only
module sas_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [16:0] rect_x,
  input logic [1:0] facing,
  input logic       motion_state
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(rect_x) && $stable(facing))
    else $error("stalled result changed");
  a_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid after reset");
  a_ms: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(motion_state))
    else $error("motion state changed under stall");
endmodule

bind sprite_animation_sequencer sas_checker u_sas_checker (
  .clk, .rst, .out_valid, .out_stall, .rect_x, .facing, .motion_state
);
